[rtl/mdte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdte_pkg
// Shared constants, payload types and the note frequency ROM of the MIDI
// delta time encoder.
// ----------------------------------------------------------------------------
package mdte_pkg;

  localparam int KEY_COUNT      = 88;
  localparam int FREQ_FRAC_BITS = 11;
  localparam int LOWEST_NOTE    = 21;

  localparam int TICK_W   = 32;
  localparam int NOTE_W   = 7;
  localparam int REST_W   = 16;
  localparam int KIDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  // unsigned 13.F note frequency
  localparam int FREQ_W   = 13 + FREQ_FRAC_BITS;
  localparam int DIV_W    = FREQ_W + 1;
  localparam int SCALE_SH = FREQ_FRAC_BITS + 5;
  localparam int NUM_W    = TICK_W + SCALE_SH + 1;
  localparam int DELTA_W  = NUM_W + 3;

  localparam logic [27:0] DELTA_MAX = 28'h0FFF_FFFF;
  localparam logic [27:0] LIM_1B    = 28'd127;
  localparam logic [27:0] LIM_2B    = 28'd16383;
  localparam logic [27:0] LIM_3B    = 28'd2097151;
  localparam logic [REST_W-1:0] REST_RESET = 16'd2000;

  typedef logic [FREQ_W-1:0] freq_rom_t [KEY_COUNT];

  // Build 27.5 * 2^(k/12) Hz per key from the semitone ratios (2.28 format)
  function automatic freq_rom_t build_freq_rom();
    freq_rom_t   rom;
    logic [63:0] x;
    logic [31:0] ratio [12];
    ratio = '{32'd268435456, 32'd284397459, 32'd301308612, 32'd319225354,
              32'd338207482, 32'd358318345, 32'd379625062, 32'd402198743,
              32'd426114725, 32'd451452825, 32'd478297607, 32'd506738663};
    for (int k = 0; k < KEY_COUNT; k++) begin
      x = 64'd55 * {32'd0, ratio[k % 12]};
      x = x << (k / 12 + FREQ_FRAC_BITS);
      x = (x + (64'd1 << 28)) >> 29;
      rom[k] = x[FREQ_W-1:0];
    end
    return rom;
  endfunction

  localparam freq_rom_t FREQ_ROM = build_freq_rom();

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic              key_pressed;
    logic [NOTE_W-1:0] note_number;
  } in_t;

  typedef struct packed {
    logic [2:0] byte_count;
    logic [7:0] delta_byte0;
    logic [7:0] delta_byte1;
    logic [7:0] delta_byte2;
    logic [7:0] delta_byte3;
    logic       note_error;
    logic       delta_saturated;
  } out_t;

  // Division job handed from the front to the back
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] div;
    logic             err;
  } job_t;

endpackage

[rtl/mdte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdte_front
// Holds the rest rate register and turns an input transaction into a
// numerator, divisor and error flag for the divider.
// ----------------------------------------------------------------------------
module mdte_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  input  mdte_pkg::in_t         in_data_i,
  output mdte_pkg::job_t        job_o
);
  import mdte_pkg::*;

  logic [REST_W-1:0] rest_q;
  logic              in_range;
  logic [KIDX_W-1:0] key_idx;
  logic [FREQ_W-1:0] freq;
  logic [REST_W-1:0] rest_rate;

  // Hold the rest tick rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= REST_RESET;
    end else if (cfg_valid_i) begin
      rest_q <= cfg_data_i;
    end
  end

  // Look up the note frequency
  always_comb begin
    in_range = ({25'd0, in_data_i.note_number} >= LOWEST_NOTE) &&
               ({25'd0, in_data_i.note_number} < LOWEST_NOTE + KEY_COUNT);
    key_idx  = in_range ? KIDX_W'(in_data_i.note_number - NOTE_W'(LOWEST_NOTE))
                        : '0;
    freq      = FREQ_ROM[key_idx];
    rest_rate = (rest_q == '0) ? REST_W'(1) : rest_q;
  end

  // Select numerator and divisor
  always_comb begin
    if (in_data_i.key_pressed) begin
      job_o.num = NUM_W'({in_data_i.tick_count, SCALE_SH'(0)}) + NUM_W'(freq);
      job_o.div = {freq, 1'b0};
      job_o.err = !in_range;
    end else begin
      job_o.num = NUM_W'({in_data_i.tick_count, 6'd0}) + NUM_W'(rest_rate);
      job_o.div = DIV_W'({rest_rate, 1'b0});
      job_o.err = 1'b0;
    end
  end

endmodule

[rtl/mdte_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdte_fifo
// Two-entry job queue between the front and the divider pipeline.
// ----------------------------------------------------------------------------
module mdte_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mdte_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mdte_pkg::job_t head_o
);
  import mdte_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/mdte_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdte_back
// Bit-per-stage restoring divider, then delta scaling, saturation and
// variable-length byte packing into the output register.
// ----------------------------------------------------------------------------
module mdte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  mdte_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mdte_pkg::out_t out_data_o
);
  import mdte_pkg::*;

  logic             adv;
  logic             v_q  [NUM_W];
  logic [DIV_W-1:0] pr_q [NUM_W];
  logic [NUM_W-1:0] nq_q [NUM_W];
  logic [DIV_W-1:0] d_q  [NUM_W];
  logic             e_q  [NUM_W];
  logic             ov_q;
  out_t             od_q;

  // Advance the whole pipe when the output register can take a transaction
  assign adv         = !ov_q || !out_stall_i;
  assign job_pop_o   = adv && job_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             v_in, e_in;
    logic [DIV_W-1:0] pr_in, d_in;
    logic [NUM_W-1:0] nq_in;
    logic [DIV_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in  = job_valid_i;
      assign pr_in = '0;
      assign nq_in = job_i.num;
      assign d_in  = job_i.div;
      assign e_in  = job_i.err;
    end else begin : g_next
      assign v_in  = v_q[s-1];
      assign pr_in = pr_q[s-1];
      assign nq_in = nq_q[s-1];
      assign d_in  = d_q[s-1];
      assign e_in  = e_q[s-1];
    end

    // Shift in one numerator bit and try a subtract
    assign trial = {pr_in, nq_in[NUM_W-1]};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pr_q[s] <= ge ? DIV_W'(trial - {1'b0, d_in}) : DIV_W'(trial);
        nq_q[s] <= {nq_in[NUM_W-2:0], ge};
        d_q[s]  <= d_in;
        e_q[s]  <= e_in;
      end
    end
  end

  // Scale, clamp and pack the delta
  logic [DELTA_W-1:0] delta;
  logic               sat;
  logic [27:0]        dv;
  out_t               enc;

  always_comb begin
    delta = DELTA_W'({nq_q[NUM_W-1], 2'b00}) + DELTA_W'({nq_q[NUM_W-1], 1'b0});
    sat   = (delta > DELTA_W'(DELTA_MAX));
    dv    = sat ? DELTA_MAX : delta[27:0];
    enc   = '0;
    enc.delta_saturated = sat;
    priority if (dv > LIM_3B) begin
      enc.byte_count  = 3'd4;
      enc.delta_byte0 = {1'b1, dv[27:21]};
      enc.delta_byte1 = {1'b1, dv[20:14]};
      enc.delta_byte2 = {1'b1, dv[13:7]};
      enc.delta_byte3 = {1'b0, dv[6:0]};
    end else if (dv > LIM_2B) begin
      enc.byte_count  = 3'd3;
      enc.delta_byte0 = {1'b1, dv[20:14]};
      enc.delta_byte1 = {1'b1, dv[13:7]};
      enc.delta_byte2 = {1'b0, dv[6:0]};
    end else if (dv > LIM_1B) begin
      enc.byte_count  = 3'd2;
      enc.delta_byte0 = {1'b1, dv[13:7]};
      enc.delta_byte1 = {1'b0, dv[6:0]};
    end else begin
      enc.byte_count  = 3'd1;
      enc.delta_byte0 = {1'b0, dv[6:0]};
    end
    // Drop everything for a bad note
    if (e_q[NUM_W-1]) begin
      enc            = '0;
      enc.note_error = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= v_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q <= enc;
    end
  end

endmodule

[rtl/midi_delta_time_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_delta_time_encoder
// Converts timer tick counts to MIDI delta times as variable-length bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
//   event with the tick count, pressed flag and note number.
//   Output channel (out_valid_o / out_stall_i / out_data_o): one transaction
//   per input with byte count, four bytes and the error/saturation flags.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes the rest
//   tick rate; always ready. Write only while the block is idle.
//   Throughput: one transaction per cycle unless the receiver stalls. An accepted
//   input passes the job queue, the 49-stage bit-per-stage divider and the
//   output register on its way to output valid.
//   Reset: the pipeline and queue empty, the rest rate returns to 2000.
//   Receiver stall: the divider pipe freezes; the two-entry queue absorbs
//   input until full, then in_stall_o rises.
// ----------------------------------------------------------------------------
module midi_delta_time_encoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mdte_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mdte_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import mdte_pkg::*;

  job_t job, head;
  logic full, empty, pop, push;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;

  mdte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .job_o       (job)
  );

  mdte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  mdte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (head),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Error results carry no bytes
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.note_error |->
      out_data_o.byte_count == 3'd0 && !out_data_o.delta_saturated)
    else $error("note error with bytes");

  // A clamped delta always spans four bytes
  a_sat_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.delta_saturated |-> out_data_o.byte_count == 3'd4)
    else $error("saturated delta not four bytes");

  // Good results carry one to four bytes
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.note_error |->
      out_data_o.byte_count != 3'd0 && out_data_o.byte_count <= 3'd4)
    else $error("bad byte count");

  // Never pop an empty queue
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule
